@@ rtl/smaa_pkg.sv @@
// Package for the sensor moving average alarm block.
// Parameter defaults, operation and status codes, FSM states, and the
// controller/datapath command and status structs. No dependencies.
package smaa_pkg;

   localparam int SENSORS_DEF = 16;
   localparam int WINDOW_DEF  = 8;

   localparam logic OP_MAP  = 1'b0;
   localparam logic OP_MEAS = 1'b1;

   localparam logic CSR_MIN_TEMP = 1'b0;
   localparam logic CSR_MAX_TEMP = 1'b1;

   localparam logic signed [15:0] MIN_TEMP_RESET = 16'sd2560;
   localparam logic signed [15:0] MAX_TEMP_RESET = 16'sd5120;

   typedef enum logic [2:0] {
      STAT_MAPPED   = 3'd0,
      STAT_IN_RANGE = 3'd1,
      STAT_COLD     = 3'd2,
      STAT_HOT      = 3'd3,
      STAT_FILLING  = 3'd4,
      STAT_UNKNOWN  = 3'd5,
      STAT_FULL     = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_ACT,
      S_RD_ACC,
      S_RD_WIN,
      S_UPD,
      S_DIV,
      S_FIN
   } state_type;

   typedef enum logic [1:0] {
      RES_MAP,
      RES_FULL,
      RES_UNKNOWN,
      RES_MEAS
   } res_kind_type;

   typedef struct packed {
      logic         take;
      logic         scan_run;
      logic         latch_sel;
      logic         map_write;
      logic         meas_write;
      logic         res_load;
      res_kind_type res_kind;
   } cmd_type;

   typedef struct packed {
      logic op;
      logic scan_end;
      logic hit;
      logic free;
      logic out_free;
   } stat_type;

endpackage

@@ rtl/smaa_if.sv @@
// Request and response channel interfaces for the sensor moving average alarm.
// Valid/ready handshake; a word moves when both are high. No dependencies.
interface smaa_req_if;
   logic               valid;
   logic               ready;
   logic               op;
   logic [15:0]        probe_id;
   logic [15:0]        room_id;
   logic signed [15:0] temperature;
   logic [31:0]        timestamp;

   modport source (output valid, op, probe_id, room_id, temperature, timestamp,
                   input ready);
   modport sink   (input valid, op, probe_id, room_id, temperature, timestamp,
                   output ready);
endinterface

interface smaa_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         status;
   logic [15:0]        room_id_res;
   logic signed [15:0] running_avg;
   logic [31:0]        last_time;

   modport source (output valid, status, room_id_res, running_avg, last_time,
                   input ready);
   modport sink   (input valid, status, room_id_res, running_avg, last_time,
                   output ready);
endinterface

@@ rtl/sensor_moving_average_alarm.sv @@
// Top level of the sensor moving average alarm.
// Joins smaa_ctrl and smaa_dp; uses smaa_pkg and the smaa_req_if/smaa_rsp_if channels.
//
// Usage:
//   req_ch carries map words (op 0: sensor id, room id) and measurement words
//   (op 1: sensor id, temperature, timestamp). Each word yields one rsp_ch word.
//   csr_write/csr_index/csr_data set min_temp (index 0) and max_temp (index 1);
//   write them only while the block is idle.
//   A word is taken only in the idle state, so one word is in work at a time.
//   The sensor id search reads the entry table one entry per cycle and stops
//   at the first hit or after the last entry.
//   Map, unknown and full results are loaded after the search; measurements
//   then go through accumulator read, window read, update, reciprocal
//   multiply and result. The next word can be accepted in the cycle after
//   the result is loaded.
//   The result sits in an output register; a stalled receiver blocks only the
//   final load, and a new word may be searched meanwhile.
//   Reset clears the entry valid bits, the result valid and the thresholds
//   (10.0 and 20.0 degrees); the RAMs need no clearing pass.
module sensor_moving_average_alarm #(
   parameter int SENSORS = smaa_pkg::SENSORS_DEF,
   parameter int WINDOW  = smaa_pkg::WINDOW_DEF
) (
   input  logic        clock,
   input  logic        reset,
   smaa_req_if.sink    req_ch,
   smaa_rsp_if.source  rsp_ch,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [15:0] csr_data
);
   import smaa_pkg::*;

   cmd_type  cmd;
   stat_type st;

   smaa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .st        (st),
      .cmd       (cmd)
   );

   smaa_dp #(.SENSORS(SENSORS), .WINDOW(WINDOW)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_op          (req_ch.op),
      .req_probe_id    (req_ch.probe_id),
      .req_room_id     (req_ch.room_id),
      .req_temperature (req_ch.temperature),
      .req_timestamp   (req_ch.timestamp),
      .cmd             (cmd),
      .st              (st),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .rsp_valid       (rsp_ch.valid),
      .rsp_ready       (rsp_ch.ready),
      .rsp_status      (rsp_ch.status),
      .rsp_room_id_res (rsp_ch.room_id_res),
      .rsp_running_avg (rsp_ch.running_avg),
      .rsp_last_time   (rsp_ch.last_time)
   );
endmodule

@@ rtl/smaa_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module smaa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

@@ rtl/smaa_ctrl.sv @@
// Controller FSM for the sensor moving average alarm.
// Sequences scan, map/measure update and result load; uses smaa_pkg.
module smaa_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  smaa_pkg::stat_type st,
   output smaa_pkg::cmd_type  cmd
);
   import smaa_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan_run = 1'b1;
            if (st.scan_end) begin
               cmd.latch_sel = 1'b1;
               state_in      = S_ACT;
            end
         end
         S_ACT: begin
            if (st.op == OP_MEAS && st.hit) begin
               state_in = S_RD_ACC;
            end else if (st.out_free) begin
               cmd.res_load = 1'b1;
               state_in     = S_IDLE;
               if (st.op == OP_MAP) begin
                  if (st.hit || st.free) begin
                     cmd.map_write = 1'b1;
                     cmd.res_kind  = RES_MAP;
                  end else begin
                     cmd.res_kind = RES_FULL;
                  end
               end else begin
                  cmd.res_kind = RES_UNKNOWN;
               end
            end
         end
         S_RD_ACC: state_in = S_RD_WIN;
         S_RD_WIN: state_in = S_UPD;
         S_UPD: begin
            cmd.meas_write = 1'b1;
            state_in       = S_DIV;
         end
         S_DIV: state_in = S_FIN;
         S_FIN: begin
            if (st.out_free) begin
               cmd.res_load = 1'b1;
               cmd.res_kind = RES_MEAS;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule

@@ rtl/smaa_dp.sv @@
// Datapath for the sensor moving average alarm: entry table RAMs, sample
// window RAM, sum/average arithmetic, thresholds and result register.
// Uses smaa_pkg and smaa_ram.
module smaa_dp #(
   parameter int SENSORS = smaa_pkg::SENSORS_DEF,
   parameter int WINDOW  = smaa_pkg::WINDOW_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_op,
   input  logic [15:0]        req_probe_id,
   input  logic [15:0]        req_room_id,
   input  logic signed [15:0] req_temperature,
   input  logic [31:0]        req_timestamp,
   input  smaa_pkg::cmd_type  cmd,
   output smaa_pkg::stat_type st,
   input  logic               csr_write,
   input  logic               csr_index,
   input  logic [15:0]        csr_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_status,
   output logic [15:0]        rsp_room_id_res,
   output logic signed [15:0] rsp_running_avg,
   output logic [31:0]        rsp_last_time
);
   import smaa_pkg::*;

   localparam int ENT_W   = SENSORS > 1 ? $clog2(SENSORS) : 1;
   localparam int L_W     = $clog2(WINDOW);
   localparam int PTR_W   = WINDOW > 1 ? L_W : 1;
   localparam int FILL_W  = $clog2(WINDOW + 1);
   localparam int SUM_W   = 16 + L_W;
   localparam int MAG_W   = SUM_W;
   localparam int ACC_W   = SUM_W + FILL_W + PTR_W + 32;
   localparam int WDEPTH  = SENSORS * WINDOW;
   localparam int WIN_AW  = WDEPTH > 1 ? $clog2(WDEPTH) : 1;
   localparam int SH      = MAG_W + L_W;
   localparam int PROD_W  = 2 * MAG_W + 1;
   localparam longint RECIP = ((64'd1 << SH) + WINDOW - 1) / WINDOW;

   // request word
   logic               op_ff;
   logic [15:0]        id_ff, room_ff;
   logic signed [15:0] temp_ff;
   logic [31:0]        ts_ff;

   // thresholds
   logic signed [15:0] min_ff, max_ff;

   // scan
   logic [ENT_W-1:0] scan_addr_ff, chk_idx_ff, free_idx_ff, sel_ff;
   logic             chk_live_ff, free_found_ff, hit_ff, free_ff;
   logic [15:0]      hit_room_ff;
   logic             valid_ff [SENSORS];
   logic             hit_now, chk_last, free_any;

   // RAM ports
   logic [31:0]       meta_rd;
   logic [ACC_W-1:0]  acc_rd, acc_wr;
   logic              acc_we;
   logic [15:0]       win_rd;
   logic [WIN_AW-1:0] win_addr;

   // arithmetic
   logic signed [SUM_W-1:0] acc_sum, sum_ff;
   logic [FILL_W-1:0]       acc_fill, fill_ff, fill_new;
   logic [PTR_W-1:0]        acc_wp, wp_new;
   logic signed [SUM_W:0]   sum_new, drop;
   logic [MAG_W-1:0]        mag;
   logic [PROD_W-1:0]       prod_ff;
   logic                    neg_ff;
   logic [16:0]             quo, avg17;
   logic signed [15:0]      avg;
   status_type              meas_stat;

   // result register
   logic               rsp_valid_ff;
   logic [2:0]         rsp_status_ff;
   logic [15:0]        rsp_room_ff;
   logic signed [15:0] rsp_avg_ff;
   logic [31:0]        rsp_time_ff;

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         op_ff   <= req_op;
         id_ff   <= req_probe_id;
         room_ff <= req_room_id;
         temp_ff <= req_temperature;
         ts_ff   <= req_timestamp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= MIN_TEMP_RESET;
         max_ff <= MAX_TEMP_RESET;
      end else if (csr_write) begin
         if (csr_index == CSR_MIN_TEMP) begin
            min_ff <= csr_data;
         end else begin
            max_ff <= csr_data;
         end
      end
   end

   // entry scan: read issued at scan_addr, compared in the next cycle
   assign hit_now  = chk_live_ff && valid_ff[chk_idx_ff] && (meta_rd[31:16] == id_ff);
   assign chk_last = chk_idx_ff == ENT_W'(SENSORS - 1);
   assign free_any = free_found_ff || !valid_ff[chk_idx_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         chk_live_ff   <= 1'b0;
         free_found_ff <= 1'b0;
      end else if (cmd.take) begin
         chk_live_ff   <= 1'b0;
         free_found_ff <= 1'b0;
      end else if (cmd.scan_run) begin
         chk_live_ff <= 1'b1;
         if (chk_live_ff && !valid_ff[chk_idx_ff] && !free_found_ff) begin
            free_found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         scan_addr_ff <= '0;
      end else if (cmd.scan_run) begin
         scan_addr_ff <= scan_addr_ff + 1'b1;
         chk_idx_ff   <= scan_addr_ff;
         if (chk_live_ff && !valid_ff[chk_idx_ff] && !free_found_ff) begin
            free_idx_ff <= chk_idx_ff;
         end
      end
      if (cmd.latch_sel) begin
         hit_ff      <= hit_now;
         free_ff     <= free_any;
         hit_room_ff <= meta_rd[15:0];
         sel_ff      <= (hit_now || !free_found_ff) ? chk_idx_ff : free_idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SENSORS; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (cmd.map_write) begin
         valid_ff[sel_ff] <= 1'b1;
      end
   end

   smaa_ram #(.WIDTH(32), .DEPTH(SENSORS)) u_meta (
      .clock   (clock),
      .wr_en   (cmd.map_write),
      .wr_addr (sel_ff),
      .wr_data ({id_ff, room_ff}),
      .rd_addr (scan_addr_ff),
      .rd_data (meta_rd)
   );

   // accumulator word: {sum, fill, write pointer, time}
   assign acc_sum  = acc_rd[ACC_W-1 -: SUM_W];
   assign acc_fill = acc_rd[PTR_W+32 +: FILL_W];
   assign acc_wp   = acc_rd[32 +: PTR_W];

   assign drop     = (acc_fill == FILL_W'(WINDOW)) ?
                     (SUM_W+1)'(signed'(win_rd)) : '0;
   assign sum_new  = (SUM_W+1)'(acc_sum) - drop + (SUM_W+1)'(temp_ff);
   assign fill_new = (acc_fill == FILL_W'(WINDOW)) ? acc_fill : acc_fill + 1'b1;
   assign wp_new   = (acc_wp == PTR_W'(WINDOW - 1)) ? '0 : acc_wp + 1'b1;

   assign acc_we = cmd.map_write || cmd.meas_write;
   assign acc_wr = cmd.meas_write ? {sum_new[SUM_W-1:0], fill_new, wp_new, ts_ff}
                                  : '0;

   smaa_ram #(.WIDTH(ACC_W), .DEPTH(SENSORS)) u_acc (
      .clock   (clock),
      .wr_en   (acc_we),
      .wr_addr (sel_ff),
      .wr_data (acc_wr),
      .rd_addr (sel_ff),
      .rd_data (acc_rd)
   );

   assign win_addr = WIN_AW'(sel_ff) * WIN_AW'(WINDOW) + WIN_AW'(acc_wp);

   smaa_ram #(.WIDTH(16), .DEPTH(WDEPTH)) u_win (
      .clock   (clock),
      .wr_en   (cmd.meas_write),
      .wr_addr (win_addr),
      .wr_data (temp_ff),
      .rd_addr (win_addr),
      .rd_data (win_rd)
   );

   always_ff @(posedge clock) begin
      if (cmd.meas_write) begin
         sum_ff  <= sum_new[SUM_W-1:0];
         fill_ff <= fill_new;
      end
   end

   // truncating divide by WINDOW: magnitude times reciprocal, then sign
   assign mag = sum_ff[SUM_W-1] ? MAG_W'(-sum_ff) : MAG_W'(sum_ff);

   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(mag) * PROD_W'(RECIP);
      neg_ff  <= sum_ff[SUM_W-1];
   end

   assign quo   = prod_ff[SH +: 17];
   assign avg17 = neg_ff ? -quo : quo;
   assign avg   = avg17[15:0];

   always_comb begin
      if (fill_ff != FILL_W'(WINDOW)) begin
         meas_stat = STAT_FILLING;
      end else if (avg < min_ff) begin
         meas_stat = STAT_COLD;
      end else if (avg > max_ff) begin
         meas_stat = STAT_HOT;
      end else begin
         meas_stat = STAT_IN_RANGE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.res_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.res_load) begin
         rsp_room_ff <= '0;
         rsp_avg_ff  <= '0;
         rsp_time_ff <= '0;
         case (cmd.res_kind)
            RES_MAP: begin
               rsp_status_ff <= STAT_MAPPED;
               rsp_room_ff   <= room_ff;
            end
            RES_FULL:    rsp_status_ff <= STAT_FULL;
            RES_UNKNOWN: rsp_status_ff <= STAT_UNKNOWN;
            default: begin
               rsp_status_ff <= meas_stat;
               rsp_room_ff   <= hit_room_ff;
               rsp_avg_ff    <= avg;
               rsp_time_ff   <= ts_ff;
            end
         endcase
      end
   end

   assign st.op       = op_ff;
   assign st.scan_end = hit_now || (chk_live_ff && chk_last);
   assign st.hit      = hit_ff;
   assign st.free     = free_ff;
   assign st.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_room_id_res = rsp_room_ff;
   assign rsp_running_avg = rsp_avg_ff;
   assign rsp_last_time   = rsp_time_ff;
endmodule

@@ rtl/smaa_chk.sv @@
// Port-level checker for the sensor moving average alarm, bound to the top.
// Uses smaa_pkg status codes.
module smaa_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_status,
   input logic [15:0] rsp_room,
   input logic [15:0] rsp_avg,
   input logic [31:0] rsp_time
);
   import smaa_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_room) && $stable(rsp_avg) && $stable(rsp_time))
      else $error("stalled response word changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a word is in work");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STAT_UNKNOWN || rsp_status == STAT_FULL) |->
      rsp_room == '0 && rsp_avg == '0 && rsp_time == '0)
      else $error("unknown or full result carries data");
endmodule

bind sensor_moving_average_alarm smaa_chk u_chk (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_status (rsp_ch.status),
   .rsp_room   (rsp_ch.room_id_res),
   .rsp_avg    (rsp_ch.running_avg),
   .rsp_time   (rsp_ch.last_time)
);
